[hw/rtl/ppbt_pkg.sv]
package ppbt_pkg;

	// default table sizes
	localparam int PEER_SLOTS_DEF  = 16;
	localparam int BAN_ENTRIES_DEF = 16;

	// field widths
	localparam int ADDR_W    = 32;
	localparam int SCORE_W   = 13;
	localparam int PEN_W     = 10;
	localparam int THR_W     = 12;
	localparam int DECAY_W   = 10;
	localparam int REM_W     = 8;
	localparam int SLOT_OUT_W = 4;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_BAN_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_AMOUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAN_SWEEPS    = 2'd2;

	localparam logic [THR_W-1:0]   THRESHOLD_RST  = 12'd1000;
	localparam logic [DECAY_W-1:0] DECAY_RST      = 10'd100;
	localparam logic [REM_W-1:0]   BAN_SWEEPS_RST = 8'd24;

	localparam logic [SCORE_W-1:0] SCORE_MAX = 13'd8191;

	typedef enum logic [1:0] {
		CMD_ACCEPT  = 2'd0,
		CMD_PUNISH  = 2'd1,
		CMD_SWEEP   = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BANNED   = 3'd1,
		ST_FULL     = 3'd2,
		ST_IGNORED  = 3'd3,
		ST_BAN_FULL = 3'd4
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [SCORE_W-1:0] score;
	} slot_ent_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [REM_W-1:0]  rem;
	} ban_ent_t;

	// results of the score and ban-age arithmetic
	typedef struct packed {
		logic [SCORE_W-1:0] punish_score;
		logic               punish_ban;
		logic [SCORE_W-1:0] decay_score;
		logic [REM_W-1:0]   rem_next;
		logic               rem_expire;
	} alu_t;

endpackage

[hw/rtl/ppbt_if.sv]
interface ppbt_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic [ppbt_pkg::ADDR_W-1:0]   peer_address;
	logic [ppbt_pkg::SLOT_OUT_W-1:0] slot_index;
	logic [ppbt_pkg::PEN_W-1:0]    penalty;

	modport source (output valid, output cmd, output peer_address, output slot_index,
		output penalty, input ready);
	modport sink (input valid, input cmd, input peer_address, input slot_index,
		input penalty, output ready);
endinterface

interface ppbt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [2:0]                      status;
	logic [ppbt_pkg::SLOT_OUT_W-1:0] slot_out;
	logic [ppbt_pkg::SCORE_W-1:0]    score_out;

	modport source (output valid, output status, output slot_out, output score_out,
		input ready);
	modport sink (input valid, input status, input slot_out, input score_out,
		output ready);
endinterface

[hw/rtl/ppbt_alu.sv]
module ppbt_alu (
	input  logic [ppbt_pkg::SCORE_W-1:0] score,
	input  logic [ppbt_pkg::PEN_W-1:0]   penalty,
	input  logic [ppbt_pkg::THR_W-1:0]   threshold,
	input  logic [ppbt_pkg::DECAY_W-1:0] decay,
	input  logic [ppbt_pkg::REM_W-1:0]   rem,
	output ppbt_pkg::alu_t               res
);

	logic [ppbt_pkg::SCORE_W:0]   sum;
	logic [ppbt_pkg::SCORE_W-1:0] sat;
	logic [ppbt_pkg::SCORE_W-1:0] decay_ext;

	// add the penalty and saturate at the score ceiling
	assign sum = {1'b0, score} + (ppbt_pkg::SCORE_W + 1)'(penalty);
	assign sat = sum[ppbt_pkg::SCORE_W] ? ppbt_pkg::SCORE_MAX : sum[ppbt_pkg::SCORE_W-1:0];

	assign decay_ext = ppbt_pkg::SCORE_W'(decay);

	always_comb begin
		res.punish_score = sat;
		res.punish_ban   = sat >= ppbt_pkg::SCORE_W'(threshold);
		// floor the decayed score at zero
		res.decay_score  = (score > decay_ext) ? score - decay_ext : '0;
		res.rem_next     = rem - 8'd1;
		res.rem_expire   = rem <= 8'd1;
	end

endmodule

[hw/rtl/peer_penalty_ban_table_top.sv]
// Peer penalty and ban table.
// Commands enter on req (valid/ready): accept an address, punish a slot, sweep,
// release a slot. One result leaves on rsp (valid/ready) per command. Registers
// ban_threshold, decay_amount and ban_sweeps are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block does not enforce. One command is worked at a time;
// req.ready is high while the sequencer idles. Release, and punish of an unknown
// slot, go straight to the result; punish updates the slot and, when it gets
// banned, searches for a free ban entry.
// Accept and sweep walk the slot and ban memories one entry a cycle through
// their single read port; a new ban searches the ban valid bits one a cycle.
// The result sits in an output register, so the next command is taken while a
// result waits; a stalled receiver only holds back the finish of the next
// command. Reset clears all slot and ban valid bits at once and loads the
// register defaults; no clearing pass runs.
module peer_penalty_ban_table_top #(
	parameter int PEER_SLOTS  = ppbt_pkg::PEER_SLOTS_DEF,
	parameter int BAN_ENTRIES = ppbt_pkg::BAN_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ppbt_req_if.sink                          req,
	ppbt_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [ppbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppbt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SLOT_W = $clog2(PEER_SLOTS);
	localparam int BAN_W  = (BAN_ENTRIES > 1) ? $clog2(BAN_ENTRIES) : 1;
	localparam int SCAN_N = (PEER_SLOTS > BAN_ENTRIES) ? PEER_SLOTS : BAN_ENTRIES;
	localparam int IDX_W  = $clog2(SCAN_N);
	localparam logic [IDX_W:0]   PEER_LIM   = (IDX_W + 1)'(PEER_SLOTS);
	localparam logic [IDX_W:0]   BAN_LIM    = (IDX_W + 1)'(BAN_ENTRIES);
	localparam logic [IDX_W-1:0] SCAN_LAST  = IDX_W'(SCAN_N - 1);
	localparam logic [IDX_W-1:0] BAN_LAST   = IDX_W'(BAN_ENTRIES - 1);
	localparam logic [8:0]       SLOT_RANGE = 9'(PEER_SLOTS);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ASCAN = 8'b0000_0010,
		S_ACHK  = 8'b0000_0100,
		S_PUPD  = 8'b0000_1000,
		S_BFIND = 8'b0001_0000,
		S_SWEEP = 8'b0010_0000,
		S_SWEND = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [ppbt_pkg::THR_W-1:0]   thr_q;
	logic [ppbt_pkg::DECAY_W-1:0] decay_q;
	logic [ppbt_pkg::REM_W-1:0]   ban_sweeps_q;

	// valid bits
	logic [PEER_SLOTS-1:0]  slot_valid_q;
	logic [BAN_ENTRIES-1:0] ban_valid_q;

	// working registers
	logic [IDX_W-1:0]              cnt_q;
	logic [ppbt_pkg::ADDR_W-1:0]   addr_q;
	logic [ppbt_pkg::PEN_W-1:0]    pen_q;
	logic [SLOT_W-1:0]             idx_q;
	logic [SLOT_W-1:0]             free_q;
	logic                          found_q;
	logic                          banned_q;
	logic                          chk_s1;
	logic                          sv_s1;
	logic                          bv_s1;
	logic [IDX_W-1:0]              sidx_s1;

	// result and output registers
	logic [2:0]                      res_status_q;
	logic [ppbt_pkg::SLOT_OUT_W-1:0] res_slot_q;
	logic [ppbt_pkg::SCORE_W-1:0]    res_score_q;
	logic                            out_valid_q;
	logic [2:0]                      out_status_q;
	logic [ppbt_pkg::SLOT_OUT_W-1:0] out_slot_q;
	logic [ppbt_pkg::SCORE_W-1:0]    out_score_q;

	// memories
	ppbt_pkg::slot_ent_t slot_mem [PEER_SLOTS];
	ppbt_pkg::ban_ent_t  ban_mem [BAN_ENTRIES];
	ppbt_pkg::slot_ent_t slot_rd_q;
	ppbt_pkg::ban_ent_t  ban_rd_q;
	ppbt_pkg::slot_ent_t slot_wdata;
	ppbt_pkg::ban_ent_t  ban_wdata;
	logic                slot_we;
	logic                ban_we;
	logic [SLOT_W-1:0]   slot_waddr;
	logic [SLOT_W-1:0]   slot_raddr;
	logic [BAN_W-1:0]    ban_waddr;

	ppbt_pkg::alu_t alu;

	logic              req_fire;
	logic [SLOT_W-1:0] in_slot;
	logic              in_known;
	logic              cnt_peer_ok;
	logic              cnt_ban_ok;
	logic [SLOT_W-1:0] cnt_slot;
	logic [BAN_W-1:0]  cnt_ban;
	logic [SLOT_W-1:0] sidx_slot;
	logic [BAN_W-1:0]  sidx_ban;
	logic              ban_hit;
	logic              acc_banned;
	logic              acc_alloc;
	logic              res_load;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign in_slot  = SLOT_W'(req.slot_index);
	assign in_known = (9'(req.slot_index) < SLOT_RANGE) && slot_valid_q[in_slot];

	assign cnt_peer_ok = {1'b0, cnt_q} < PEER_LIM;
	assign cnt_ban_ok  = {1'b0, cnt_q} < BAN_LIM;
	assign cnt_slot    = cnt_q[SLOT_W-1:0];
	assign cnt_ban     = cnt_q[BAN_W-1:0];
	assign sidx_slot   = sidx_s1[SLOT_W-1:0];
	assign sidx_ban    = sidx_s1[BAN_W-1:0];

	// compare the ban entry read in the previous scan cycle
	assign ban_hit    = chk_s1 && (ban_rd_q.addr == addr_q);
	assign acc_banned = banned_q || ban_hit;
	assign acc_alloc  = (state_q == S_ACHK) && !acc_banned && found_q;

	assign res_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	ppbt_alu u_alu (
		.score     (slot_rd_q.score),
		.penalty   (pen_q),
		.threshold (thr_q),
		.decay     (decay_q),
		.rem       (ban_rd_q.rem),
		.res       (alu)
	);

	// select slot memory write
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = '{addr: slot_rd_q.addr, score: alu.punish_score};
		case (state_q)
			S_ACHK: begin
				slot_we    = acc_alloc;
				slot_waddr = free_q;
				slot_wdata = '{addr: addr_q, score: '0};
			end
			S_PUPD: begin
				slot_we = 1'b1;
			end
			S_SWEEP, S_SWEND: begin
				slot_we    = sv_s1;
				slot_waddr = sidx_slot;
				slot_wdata = '{addr: slot_rd_q.addr, score: alu.decay_score};
			end
			default: begin
				slot_we = 1'b0;
			end
		endcase
	end

	assign slot_raddr = (state_q == S_IDLE) ? in_slot : cnt_slot;

	// select ban memory write
	always_comb begin
		ban_we    = 1'b0;
		ban_waddr = cnt_ban;
		ban_wdata = '{addr: addr_q, rem: ban_sweeps_q};
		case (state_q)
			S_BFIND: begin
				ban_we = !ban_valid_q[cnt_ban];
			end
			S_SWEEP, S_SWEND: begin
				ban_we    = bv_s1 && !alu.rem_expire;
				ban_waddr = sidx_ban;
				ban_wdata = '{addr: ban_rd_q.addr, rem: alu.rem_next};
			end
			default: begin
				ban_we = 1'b0;
			end
		endcase
	end

	// slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd_q <= slot_mem[slot_raddr];
	end

	// ban memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (ban_we) begin
			ban_mem[ban_waddr] <= ban_wdata;
		end
		ban_rd_q <= ban_mem[cnt_ban];
	end

	// sequencer, valid bits and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			thr_q        <= ppbt_pkg::THRESHOLD_RST;
			decay_q      <= ppbt_pkg::DECAY_RST;
			ban_sweeps_q <= ppbt_pkg::BAN_SWEEPS_RST;
			slot_valid_q <= '0;
			ban_valid_q  <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			banned_q     <= 1'b0;
			chk_s1       <= 1'b0;
			sv_s1        <= 1'b0;
			bv_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ppbt_pkg::REG_BAN_THRESHOLD: thr_q <= cfg_data[ppbt_pkg::THR_W-1:0];
					ppbt_pkg::REG_DECAY_AMOUNT:  decay_q <= cfg_data[ppbt_pkg::DECAY_W-1:0];
					ppbt_pkg::REG_BAN_SWEEPS:    ban_sweeps_q <= cfg_data[ppbt_pkg::REM_W-1:0];
					default: begin
					end
				endcase
			end

			// advance the walk pipeline
			chk_s1 <= (state_q == S_ASCAN) && cnt_ban_ok && ban_valid_q[cnt_ban];
			sv_s1  <= (state_q == S_SWEEP) && cnt_peer_ok && slot_valid_q[cnt_slot];
			bv_s1  <= (state_q == S_SWEEP) && cnt_ban_ok && ban_valid_q[cnt_ban];

			// drop expired bans on sweep write-back
			if (bv_s1 && alu.rem_expire) begin
				ban_valid_q[sidx_ban] <= 1'b0;
			end

			// hand the result to the receiver
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						cnt_q    <= '0;
						found_q  <= 1'b0;
						banned_q <= 1'b0;
						case (ppbt_pkg::cmd_t'(req.cmd))
							ppbt_pkg::CMD_ACCEPT: begin
								state_q <= S_ASCAN;
							end
							ppbt_pkg::CMD_SWEEP: begin
								state_q <= S_SWEEP;
							end
							ppbt_pkg::CMD_PUNISH: begin
								state_q <= in_known ? S_PUPD : S_DONE;
							end
							ppbt_pkg::CMD_RELEASE: begin
								if (in_known) begin
									slot_valid_q[in_slot] <= 1'b0;
								end
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_ASCAN: begin
					if (ban_hit) begin
						banned_q <= 1'b1;
					end
					if (cnt_peer_ok && !slot_valid_q[cnt_slot] && !found_q) begin
						found_q <= 1'b1;
					end
					if (cnt_q == SCAN_LAST) begin
						state_q <= S_ACHK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ACHK: begin
					if (acc_alloc) begin
						slot_valid_q[free_q] <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_PUPD: begin
					if (alu.punish_ban) begin
						slot_valid_q[idx_q] <= 1'b0;
						cnt_q               <= '0;
						state_q             <= S_BFIND;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_BFIND: begin
					if (!ban_valid_q[cnt_ban]) begin
						ban_valid_q[cnt_ban] <= 1'b1;
						state_q              <= S_DONE;
					end else if (cnt_q == BAN_LAST) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SWEEP: begin
					if (cnt_q == SCAN_LAST) begin
						state_q <= S_SWEND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SWEND: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold command payload and build the result
	always_ff @(posedge clk) begin
		sidx_s1 <= cnt_q;
		case (state_q)
			S_IDLE: begin
				addr_q       <= req.peer_address;
				pen_q        <= req.penalty;
				idx_q        <= in_slot;
				res_slot_q   <= (req.cmd == ppbt_pkg::CMD_SWEEP) ? '0 : req.slot_index;
				res_score_q  <= '0;
				res_status_q <= (in_known || req.cmd == ppbt_pkg::CMD_SWEEP)
					? ppbt_pkg::ST_OK : ppbt_pkg::ST_IGNORED;
			end
			S_ASCAN: begin
				if (cnt_peer_ok && !slot_valid_q[cnt_slot] && !found_q) begin
					free_q <= cnt_slot;
				end
			end
			S_ACHK: begin
				res_score_q <= '0;
				if (acc_banned) begin
					res_status_q <= ppbt_pkg::ST_BANNED;
					res_slot_q   <= '0;
				end else if (found_q) begin
					res_status_q <= ppbt_pkg::ST_OK;
					res_slot_q   <= ppbt_pkg::SLOT_OUT_W'(free_q);
				end else begin
					res_status_q <= ppbt_pkg::ST_FULL;
					res_slot_q   <= '0;
				end
			end
			S_PUPD: begin
				addr_q       <= slot_rd_q.addr;
				res_score_q  <= alu.punish_score;
				res_status_q <= ppbt_pkg::ST_OK;
			end
			S_BFIND: begin
				res_status_q <= ban_valid_q[cnt_ban] ? ppbt_pkg::ST_BAN_FULL
					: ppbt_pkg::ST_BANNED;
			end
			default: begin
			end
		endcase
		if (res_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_score_q  <= res_score_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.slot_out  = out_slot_q;
	assign rsp.score_out = out_score_q;

	// an accept only allocates a slot that is free
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		acc_alloc |-> !slot_valid_q[free_q])
		else $error("accept allocates a slot that is in use");

	// a punish update only works on a live slot
	a_punish_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUPD) |-> slot_valid_q[idx_q])
		else $error("punish update on a free slot");

	// at most one ban is recorded per cycle
	a_ban_growth: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(ban_valid_q) <= $past($countones(ban_valid_q)) + 1))
		else $error("ban list grew by more than one entry");

	// no new command is taken in the result hold state
	a_done_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !req.ready)
		else $error("command taken before result was handed over");

endmodule

[test/tb.sv]
import ppbt_pkg::*;

typedef struct {
	status_t                 status;
	logic [SLOT_OUT_W-1:0]   slot;
	logic [SCORE_W-1:0]      score;
} verdict_t;

class ban_table_scoreboard;
	bit                  slot_live[PEER_SLOTS_DEF];
	logic [ADDR_W-1:0]   slot_addr[PEER_SLOTS_DEF];
	logic [SCORE_W-1:0]  slot_pts[PEER_SLOTS_DEF];
	bit                  ban_live[BAN_ENTRIES_DEF];
	logic [ADDR_W-1:0]   ban_addr[BAN_ENTRIES_DEF];
	logic [REM_W-1:0]    ban_left[BAN_ENTRIES_DEF];
	logic [THR_W-1:0]    threshold;
	logic [DECAY_W-1:0]  decay;
	logic [REM_W-1:0]    ban_len;
	verdict_t            pending_verdicts[$];
	int                  errors;

	function new();
		int i;
		errors = 0;
		threshold = THRESHOLD_RST;
		decay = DECAY_RST;
		ban_len = BAN_SWEEPS_RST;
		for (i = 0; i < PEER_SLOTS_DEF; i++) begin
			slot_live[i] = 1'b0;
			slot_addr[i] = '0;
			slot_pts[i] = '0;
		end
		for (i = 0; i < BAN_ENTRIES_DEF; i++) begin
			ban_live[i] = 1'b0;
			ban_addr[i] = '0;
			ban_left[i] = '0;
		end
	endfunction

	// Truncate to the register width; unknown indexes change nothing
	function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		case (index)
		REG_BAN_THRESHOLD: threshold = data[THR_W-1:0];
		REG_DECAY_AMOUNT: decay = data[DECAY_W-1:0];
		REG_BAN_SWEEPS: ban_len = data[REM_W-1:0];
		default: ;
		endcase
	endfunction

	// Pick a random occupied slot, or any slot when the table is empty
	function logic [SLOT_OUT_W-1:0] live_slot();
		int i;
		int picks[$];
		for (i = 0; i < PEER_SLOTS_DEF; i++)
			if (slot_live[i])
				picks.insert(picks.size(), i);
		if (picks.size() == 0)
			return SLOT_OUT_W'($urandom_range(PEER_SLOTS_DEF - 1));
		return SLOT_OUT_W'(picks[$urandom_range(picks.size() - 1)]);
	endfunction

	// Update the table for one accepted transaction and queue its verdict
	function void apply_command(cmd_t cmd, logic [ADDR_W-1:0] addr,
			logic [SLOT_OUT_W-1:0] idx, logic [PEN_W-1:0] pen);
		verdict_t v;
		logic [SCORE_W:0] sum;
		bit hit;
		int i;
		v.status = ST_OK;
		v.slot = '0;
		v.score = '0;
		case (cmd)
		CMD_ACCEPT: begin
			hit = 1'b0;
			for (i = 0; i < BAN_ENTRIES_DEF; i++)
				if (ban_live[i] && ban_addr[i] == addr)
					hit = 1'b1;
			if (hit) begin
				v.status = ST_BANNED;
			end else begin
				v.status = ST_FULL;
				for (i = 0; i < PEER_SLOTS_DEF; i++) begin
					if (!slot_live[i]) begin
						slot_live[i] = 1'b1;
						slot_addr[i] = addr;
						slot_pts[i] = '0;
						v.status = ST_OK;
						v.slot = SLOT_OUT_W'(i);
						break;
					end
				end
			end
		end
		CMD_SWEEP: begin
			// age bans, then decay scores with a floor of zero
			for (i = 0; i < BAN_ENTRIES_DEF; i++) begin
				if (ban_live[i]) begin
					if (ban_left[i] <= 1) begin
						ban_live[i] = 1'b0;
						ban_left[i] = '0;
					end else begin
						ban_left[i] = ban_left[i] - 1'b1;
					end
				end
			end
			for (i = 0; i < PEER_SLOTS_DEF; i++)
				if (slot_live[i])
					slot_pts[i] = (slot_pts[i] > decay) ? slot_pts[i] - decay : '0;
		end
		default: begin
			v.slot = idx;
			if (!slot_live[idx]) begin
				v.status = ST_IGNORED;
			end else if (cmd == CMD_RELEASE) begin
				slot_live[idx] = 1'b0;
			end else begin
				sum = {1'b0, slot_pts[idx]};
				sum = sum + (SCORE_W + 1)'(pen);
				if (sum > {1'b0, SCORE_MAX})
					sum = {1'b0, SCORE_MAX};
				slot_pts[idx] = sum[SCORE_W-1:0];
				v.score = slot_pts[idx];
				// free the slot and record the ban in the lowest free entry
				if (slot_pts[idx] >= threshold) begin
					slot_live[idx] = 1'b0;
					v.status = ST_BAN_FULL;
					for (i = 0; i < BAN_ENTRIES_DEF; i++) begin
						if (!ban_live[i]) begin
							ban_live[i] = 1'b1;
							ban_addr[i] = slot_addr[idx];
							ban_left[i] = ban_len;
							v.status = ST_BANNED;
							break;
						end
					end
				end
			end
		end
		endcase
		pending_verdicts.insert(pending_verdicts.size(), v);
	endfunction

	// Compare one result transaction with the oldest verdict
	function void check_result(logic [2:0] status, logic [SLOT_OUT_W-1:0] slot,
			logic [SCORE_W-1:0] score);
		verdict_t v;
		if (pending_verdicts.size() == 0) begin
			$error("unexpected result: status %0d slot %0d score %0d", status, slot, score);
			errors++;
			return;
		end
		v = pending_verdicts.pop_front();
		if (status !== v.status) begin
			$error("status: expected %0d, got %0d", v.status, status);
			errors++;
		end
		if (slot !== v.slot) begin
			$error("slot_out: expected %0d, got %0d", v.slot, slot);
			errors++;
		end
		if (score !== v.score) begin
			$error("score_out: expected %0d, got %0d", v.score, score);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    send_idle;
	int                    rcv_idle;
	int                    quiet;
	logic [ADDR_W-1:0]     addr_pool[6];
	ban_table_scoreboard   sb;

	ppbt_req_if req_ch();
	ppbt_rsp_if rsp_ch();

	peer_penalty_ban_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result channel at random
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
	end

	// Observe both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.status, rsp_ch.slot_out, rsp_ch.score_out);
			if (req_ch.valid && req_ch.ready)
				sb.apply_command(cmd_t'(req_ch.cmd), req_ch.peer_address,
					req_ch.slot_index, req_ch.penalty);
			if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
				quiet = 0;
			else
				quiet = quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("peer_penalty_ban_table_top test failed");
				$finish;
			end
		end
	end

	// Present one command transaction and hold it until accepted
	task automatic send_command(cmd_t cmd, logic [ADDR_W-1:0] addr,
			logic [SLOT_OUT_W-1:0] idx, logic [PEN_W-1:0] pen);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.cmd = cmd;
		req_ch.peer_address = addr;
		req_ch.slot_index = idx;
		req_ch.penalty = pen;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold off commands until every verdict has come back
	task automatic drain();
		req_ch.valid = 1'b0;
		while (sb.pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		sb.write_reg(index, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly live slots and recurring addresses, with some noise
	task automatic random_phase(int count);
		int r;
		int n;
		int k;
		cmd_t cmd;
		logic [ADDR_W-1:0] addr;
		logic [SLOT_OUT_W-1:0] idx;
		logic [PEN_W-1:0] pen;
		for (k = 0; k < 6; k++)
			addr_pool[k] = $urandom;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(99);
			addr = $urandom;
			idx = SLOT_OUT_W'($urandom_range(15));
			pen = $urandom_range(1) ? PEN_W'($urandom_range(1023))
				: PEN_W'($urandom_range(63));
			if (r < 35) begin
				cmd = CMD_ACCEPT;
				if ($urandom_range(9) < 7)
					addr = addr_pool[$urandom_range(5)];
			end else if (r < 70) begin
				cmd = CMD_PUNISH;
				if ($urandom_range(9) < 8)
					idx = sb.live_slot();
			end else if (r < 80) begin
				cmd = CMD_SWEEP;
			end else begin
				cmd = CMD_RELEASE;
				if ($urandom_range(9) < 7)
					idx = sb.live_slot();
			end
			send_command(cmd, addr, idx, pen);
			if (n == count / 2)
				drain();
		end
		drain();
	endtask

	initial begin
		int k;
		sb = new();
		quiet = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_ACCEPT;
		req_ch.peer_address = '0;
		req_ch.slot_index = '0;
		req_ch.penalty = '0;
		cfg_we = 1'b0;
		cfg_index = REG_BAN_THRESHOLD;
		cfg_data = '0;
		send_idle = 29;
		rcv_idle = 74;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset defaults, extremes, bans, unknown slots, full table
		send_command(CMD_ACCEPT, 32'h0000_0000, 4'hF, 10'h3FF);
		send_command(CMD_ACCEPT, 32'hFFFF_FFFF, 4'h0, 10'h000);
		send_command(CMD_PUNISH, 32'h1234_5678, 4'h1, 10'h3FF);
		send_command(CMD_ACCEPT, 32'hFFFF_FFFF, 4'h5, 10'h155);
		send_command(CMD_PUNISH, 32'hFFFF_FFFF, 4'hF, 10'h000);
		send_command(CMD_RELEASE, 32'h0000_0000, 4'hA, 10'h2AA);
		send_command(CMD_PUNISH, 32'h8000_0001, 4'h0, 10'd500);
		send_command(CMD_SWEEP, 32'h5555_5555, 4'h0, 10'h000);
		send_command(CMD_PUNISH, 32'hAAAA_AAAA, 4'h0, 10'h000);
		send_command(CMD_RELEASE, 32'h0000_0000, 4'h0, 10'h000);
		send_command(CMD_ACCEPT, 32'h5A5A_5A5A, 4'h0, 10'h000);
		for (k = 0; k < 16; k++)
			send_command(CMD_ACCEPT, 32'h0A00_0000 + k, 4'h0, 10'h000);
		drain();

		// Moderate threshold, long bans so the ban list fills
		load_register(REG_BAN_THRESHOLD, 12'd300);
		load_register(REG_DECAY_AMOUNT, 12'd50);
		load_register(REG_BAN_SWEEPS, 12'd255);
		random_phase(130);

		// Top of the threshold and decay ranges; upper data bits are cut off
		load_register(REG_BAN_THRESHOLD, 12'hFFF);
		load_register(REG_DECAY_AMOUNT, 12'hFFF);
		load_register(REG_BAN_SWEEPS, 12'h101);
		random_phase(130);

		// Zero threshold and zero ban time, swapped idling
		send_idle = 74;
		rcv_idle = 29;
		load_register(REG_BAN_THRESHOLD, 12'h000);
		load_register(REG_DECAY_AMOUNT, 12'hC00);
		load_register(REG_BAN_SWEEPS, 12'hF00);
		load_register(REG_UNUSED, 12'h5A5);
		random_phase(130);

		// Lowest legal threshold, full speed on both sides
		send_idle = 0;
		rcv_idle = 0;
		load_register(REG_BAN_THRESHOLD, 12'd1);
		load_register(REG_DECAY_AMOUNT, 12'd300);
		load_register(REG_BAN_SWEEPS, 12'hFFF);
		random_phase(130);

		repeat (30) @(negedge clk);
		if (sb.errors == 0 && sb.pending_verdicts.size() == 0)
			$display("peer_penalty_ban_table_top test passed");
		else
			$display("peer_penalty_ban_table_top test failed");
		$finish;
	end
endmodule

[peer_penalty_ban_table_top.f]
hw/rtl/ppbt_pkg.sv
hw/rtl/ppbt_if.sv
hw/rtl/ppbt_alu.sv
hw/rtl/peer_penalty_ban_table_top.sv
test/tb.sv
